// ----- sv/jac_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jac_pkg: shared types and constants for the Jacobi symbol block
// Symbol codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package jac_pkg;

  localparam logic signed [1:0] SYM_POS  = 2'sb01;
  localparam logic signed [1:0] SYM_ZERO = 2'sb00;
  localparam logic signed [1:0] SYM_NEG  = 2'sb11;

  typedef struct packed {
    logic load;
    logic step;
  } jac_cmd_t;

  typedef struct packed {
    logic p_bad;
    logic n_zero;
    logic p_one;
    logic neg;
  } jac_sts_t;

endpackage
`default_nettype wire

// ----- sv/jac_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jac_dp: Jacobi symbol datapath
// Holds n, p and the sign; each step does one halving, or one subtract and
// halve with an optional reciprocity swap.
// ----------------------------------------------------------------------------
module jac_dp #(
  parameter int WIDTH = 31
) (
  input  wire logic               clk,
  input  wire jac_pkg::jac_cmd_t  cmd,
  input  wire logic [WIDTH-1:0]   modulus,
  input  wire logic [WIDTH-1:0]   residue,
  output jac_pkg::jac_sts_t       sts
);
  import jac_pkg::*;

  logic [WIDTH-1:0] n_r, n_nxt;
  logic [WIDTH-1:0] p_r, p_nxt;
  logic             neg_r, neg_nxt;
  logic             ge;
  logic [WIDTH-1:0] sub_a, sub_b, diff;

  assign ge    = (n_r >= p_r);
  assign sub_a = ge ? n_r : p_r;
  assign sub_b = ge ? p_r : n_r;
  assign diff  = sub_a - sub_b;

  always_comb begin
    n_nxt   = n_r;
    p_nxt   = p_r;
    neg_nxt = neg_r;
    if (!n_r[0]) begin
      n_nxt   = n_r >> 1;
      neg_nxt = neg_r ^ (p_r[1] ^ p_r[2]);
    end else if (ge) begin
      n_nxt   = diff >> 1;
      neg_nxt = neg_r ^ (p_r[1] ^ p_r[2]);
    end else begin
      // reciprocity swap, then halve against the new modulus
      p_nxt   = n_r;
      n_nxt   = diff >> 1;
      neg_nxt = neg_r ^ (n_r[1] & p_r[1]) ^ (n_r[1] ^ n_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= residue;
      p_r   <= modulus;
      neg_r <= 1'b0;
    end else if (cmd.step) begin
      n_r   <= n_nxt;
      p_r   <= p_nxt;
      neg_r <= neg_nxt;
    end
  end

  assign sts.p_bad  = ~p_r[0];
  assign sts.n_zero = (n_r == '0);
  assign sts.p_one  = (p_r == WIDTH'(1));
  assign sts.neg    = neg_r;

endmodule
`default_nettype wire

// ----- sv/jac_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jac_ctrl: Jacobi symbol controller
// Sequences load and steps, and holds the output register and handshake.
// ----------------------------------------------------------------------------
module jac_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [1:0]       out_symbol,
  output jac_pkg::jac_cmd_t       cmd,
  input  wire jac_pkg::jac_sts_t  sts
);
  import jac_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t             state_r;
  logic               out_valid_r;
  logic signed [1:0]  symbol_r;
  logic               finish;
  logic               slot_free;
  logic               retire;
  logic signed [1:0]  result;

  assign finish    = sts.p_bad | sts.n_zero;
  assign slot_free = ~out_valid_r | out_ready;
  assign retire    = (state_r == ST_RUN) & finish & slot_free;

  always_comb begin
    if (sts.p_bad || !sts.p_one) begin
      result = SYM_ZERO;
    end else if (sts.neg) begin
      result = SYM_NEG;
    end else begin
      result = SYM_POS;
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign cmd.load   = in_ready & in_valid;
  assign cmd.step   = (state_r == ST_RUN) & ~finish;
  assign out_valid  = out_valid_r;
  assign out_symbol = symbol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      symbol_r    <= SYM_ZERO;
    end else begin
      if (retire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (retire) begin
            symbol_r <= result;
            state_r  <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/jacobi_symbol_top.sv -----
`default_nettype none
// The shared subtract-and-halve step in the datapath runs once per cycle until n
// reaches zero or the modulus is found even; one transaction runs at a time.
// A new transaction is taken while a finished result waits in the output register.
// Reset (rst_n, synchronous, active low) clears the controller and output valid.
// ----------------------------------------------------------------------------
// jacobi_symbol_top: Jacobi symbol (residue / modulus)
// Binary reciprocity method; returns -1, 0 or +1 in two's complement.
// ----------------------------------------------------------------------------
module jacobi_symbol_top #(
  parameter int WIDTH = 31
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WIDTH-1:0]  in_modulus,
  input  wire logic [WIDTH-1:0]  in_residue,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [1:0]      out_symbol
);
  import jac_pkg::*;

  jac_cmd_t cmd;
  jac_sts_t sts;

  jac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol),
    .cmd        (cmd),
    .sts        (sts)
  );

  jac_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .modulus (in_modulus),
    .residue (in_residue),
    .sts     (sts)
  );

endmodule
`default_nettype wire

// ----- tb/jacobi_symbol_top_tb.sv -----
// ----------------------------------------------------------------------------
// jacobi_symbol_top_tb: self-checking bench for the Jacobi symbol block
// A directed table of corner queries is followed by random queries. Every
// transaction is checked against its table entry, if typed, or a local Jacobi
// symbol calculator; stalls on both sides are random except in the last phase.
// ----------------------------------------------------------------------------
module jacobi_symbol_top_tb;
  import jac_pkg::*;

  localparam int W          = 31;
  localparam int PER_PHASE  = 567;
  localparam int QUIET_MAX  = 4000;
  localparam logic [W-1:0] MAX_VAL = {W{1'b1}};

  typedef struct packed {
    logic [W-1:0]      modulus;
    logic [W-1:0]      residue;
    logic              typed;
    logic signed [1:0] symbol;
  } probe_t;

  typedef struct {
    logic [W-1:0]      modulus;
    logic [W-1:0]      residue;
    logic signed [1:0] symbol;
  } pending_t;

  localparam int N_PROBES = 21;
  localparam probe_t PROBES [N_PROBES] = '{
    '{31'd0,            31'd0,            1'b1, SYM_ZERO},
    '{31'd0,            MAX_VAL,          1'b1, SYM_ZERO},
    '{31'd2,            31'd1,            1'b1, SYM_ZERO},
    '{MAX_VAL - 31'd1,  31'd5,            1'b1, SYM_ZERO},
    '{31'd1,            31'd0,            1'b1, SYM_POS},
    '{31'd1,            MAX_VAL,          1'b1, SYM_POS},
    '{MAX_VAL,          31'd0,            1'b1, SYM_ZERO},
    '{MAX_VAL,          31'd1,            1'b1, SYM_POS},
    '{MAX_VAL,          MAX_VAL - 31'd1,  1'b0, SYM_ZERO},
    '{31'd3,            31'd1,            1'b1, SYM_POS},
    '{31'd3,            31'd2,            1'b1, SYM_NEG},
    '{31'd15,           31'd6,            1'b1, SYM_ZERO},
    '{31'd9,            31'd3,            1'b1, SYM_ZERO},
    '{31'd7,            31'd9,            1'b0, SYM_ZERO},
    '{31'd5,            MAX_VAL,          1'b0, SYM_ZERO},
    '{MAX_VAL,          31'd2,            1'b0, SYM_ZERO},
    '{31'h5555_5555,    31'h2AAA_AAAA,    1'b0, SYM_ZERO},
    '{31'h2AAA_AAAB,    31'h5555_5555,    1'b0, SYM_ZERO},
    '{31'd11,           31'd8,            1'b0, SYM_ZERO},
    '{MAX_VAL,          31'h4000_0000,    1'b0, SYM_ZERO},
    '{31'd21,           31'd14,           1'b1, SYM_ZERO}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [W-1:0]        in_modulus = '0;
  logic [W-1:0]        in_residue = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [1:0]   out_symbol;

  pending_t            expected_symbols [$];
  int                  send_idle = 14;
  int                  recv_idle = 74;
  int                  fails = 0;
  int                  quiet_cycles = 0;

  jacobi_symbol_top #(
    .WIDTH(W)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_modulus (in_modulus),
    .in_residue (in_residue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_symbol (out_symbol)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [1:0] jacobi_of(logic [W-1:0] modulus,
                                                   logic [W-1:0] residue);
    logic [W-1:0] p;
    logic [W-1:0] n;
    logic [W-1:0] tmp;
    logic         flip;
    p    = modulus;
    n    = residue;
    flip = 1'b0;
    if (p == '0 || !p[0]) return SYM_ZERO;
    n = n % p;
    while (n != '0) begin
      while (!n[0]) begin
        n = n >> 1;
        if (p[2:0] == 3'd3 || p[2:0] == 3'd5) flip = ~flip;
      end
      tmp = n;
      n   = p;
      p   = tmp;
      if (n[1:0] == 2'b11 && p[1:0] == 2'b11) flip = ~flip;
      n = n % p;
    end
    if (p != W'(1)) return SYM_ZERO;
    return flip ? SYM_NEG : SYM_POS;
  endfunction

  // Odd modulus of random bit length; most queries land here.
  function automatic logic [W-1:0] odd_modulus();
    logic [W-1:0] mask;
    mask = MAX_VAL >> (W - $urandom_range(1, W));
    return (W'($urandom) & mask) | W'(1);
  endfunction

  task automatic pick_query(output logic [W-1:0] m, output logic [W-1:0] r);
    int unsigned  kind;
    logic [W-1:0] a;
    logic [W-1:0] b;
    kind = $urandom_range(99);
    if (kind < 70) begin
      m = odd_modulus();
      r = W'($urandom) % m;
    end else if (kind < 78) begin
      a = W'($urandom_range(1, 49) * 2 + 1);
      b = W'($urandom_range(0, 1 << 20)) | W'(1);
      m = a * b;
      r = a * (W'($urandom) % b);
    end else if (kind < 84) begin
      m = W'($urandom) & ~W'(1);
    end else if (kind < 90) begin
      m = odd_modulus();
      r = W'($urandom);
    end else if (kind < 94) begin
      m = W'($urandom_range(0, 1));
      r = W'($urandom);
    end else begin
      m = W'($urandom);
      r = W'($urandom);
    end
    if (kind >= 78 && kind < 84) r = W'($urandom);
  endtask

  // Entered and left at a falling edge.
  task automatic send_query(input logic [W-1:0] m, input logic [W-1:0] r,
                            input logic typed, input logic signed [1:0] sym);
    pending_t entry;
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_modulus = m;
    in_residue = r;
    do @(posedge clk); while (!in_ready);
    entry.modulus = m;
    entry.residue = r;
    entry.symbol  = typed ? sym : jacobi_of(m, r);
    expected_symbols.push_back(entry);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    pending_t head;
    if (rst_n && out_valid && out_ready) begin
      if (expected_symbols.size() == 0) begin
        $error("symbol: unexpected transaction, got %0d", out_symbol);
        fails++;
      end else begin
        head = expected_symbols.pop_front();
        if (out_symbol !== head.symbol) begin
          $error("symbol (%0d / %0d): expected %0d, got %0d",
                 head.residue, head.modulus, head.symbol, out_symbol);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [W-1:0] m;
    logic [W-1:0] r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (PROBES[k]) begin
      send_query(PROBES[k].modulus, PROBES[k].residue, PROBES[k].typed, PROBES[k].symbol);
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 14;
          recv_idle = 74;
        end
        1: begin
          send_idle = 74;
          recv_idle = 14;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (PER_PHASE) begin
        pick_query(m, r);
        send_query(m, r, 1'b0, SYM_ZERO);
      end
      drain();
    end

    repeat (2 * W + 8) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
